// ===== hw/rtl/pixel_gray_and_contrast_stretch_core_macros.svh =====
// Assertion macros shared by the pixel gray / contrast stretch RTL.
`ifndef PIXEL_GRAY_AND_CONTRAST_STRETCH_CORE_MACROS_SVH
`define PIXEL_GRAY_AND_CONTRAST_STRETCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PGCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked a fixed number of cycles after the antecedent.
`define PGCS_ASSERT_LATER(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pgcs_pkg.sv =====
// Shared types and constants for the pixel gray / contrast stretch core.
`timescale 1ns / 1ps

package pgcs_pkg;

    localparam int unsigned CHAN_W = 8;

    typedef logic [CHAN_W-1:0] t_chan;

    // Grayscale weights and the reciprocal of their sum (exact for sums below 2^15).
    localparam int unsigned W_LOW       = 34;
    localparam int unsigned W_MID       = 55;
    localparam int unsigned W_HIGH      = 11;
    localparam int unsigned RECIP_100   = 41944;
    localparam int unsigned RECIP_SHIFT = 22;
    localparam int unsigned GRAY_SUM_W  = 15;
    localparam int unsigned GRAY_PROD_W = 31;

    // Stretch lane: clip stage, numerator stage, one stage per quotient bit.
    localparam int unsigned QUO_BITS = CHAN_W;
    localparam int unsigned LANE_LAT = 2 + QUO_BITS;
    localparam int unsigned GRAY_LAT = 3;
    localparam int unsigned PIPE_LAT = LANE_LAT + 1;

    localparam logic MODE_GRAY    = 1'b0;
    localparam logic MODE_STRETCH = 1'b1;

    typedef enum logic [1:0] {
        CFG_MODE = 2'd0,
        CFG_LOW  = 2'd1,
        CFG_HIGH = 2'd2
    } t_cfg_idx;

    // One beat of the restoring divider.
    typedef struct packed {
        logic [2*CHAN_W-1:0] rem;
        t_chan               div;
        t_chan               quo;
    } t_div;

endpackage

// ===== hw/rtl/pgcs_div_step.sv =====
// One registered step of the restoring divider: resolves a single quotient bit.
`timescale 1ns / 1ps

module pgcs_div_step #(
    parameter int unsigned BIT = 0
) (
    input  logic          i_clk,
    input  pgcs_pkg::t_div i_stage,
    output pgcs_pkg::t_div o_stage
);

    logic [2*pgcs_pkg::CHAN_W-1:0] w_trial;
    pgcs_pkg::t_div                n_stage;
    pgcs_pkg::t_div                r_stage;

    assign w_trial = (2*pgcs_pkg::CHAN_W)'(i_stage.div) << BIT;

    always_comb begin
        n_stage = i_stage;
        if (i_stage.rem >= w_trial) begin
            n_stage.rem      = i_stage.rem - w_trial;
            n_stage.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_stage = r_stage;

endmodule

// ===== hw/rtl/pgcs_lane.sv =====
// One color channel of the stretch path: clip (out of range gives zero), scale by 255, divide by the span.
`timescale 1ns / 1ps

module pgcs_lane (
    input  logic            i_clk,
    input  pgcs_pkg::t_chan i_v,
    input  pgcs_pkg::t_chan i_low,
    input  pgcs_pkg::t_chan i_high,
    output pgcs_pkg::t_chan o_q
);

    logic            w_ok;
    logic            w_in;
    pgcs_pkg::t_chan n_d;
    pgcs_pkg::t_chan n_s;
    pgcs_pkg::t_chan r_d;
    pgcs_pkg::t_chan r_s;
    pgcs_pkg::t_div  r_num;
    pgcs_pkg::t_div  w_st [0:pgcs_pkg::QUO_BITS];

    // Empty or inverted range: force a zero numerator over a unit span.
    assign w_ok = i_high > i_low;
    assign w_in = (i_v >= i_low) && (i_v <= i_high);
    assign n_d  = (w_ok && w_in) ? (i_v - i_low) : '0;
    assign n_s  = w_ok ? (i_high - i_low) : pgcs_pkg::t_chan'(1);

    always_ff @(posedge i_clk) begin
        r_d       <= n_d;
        r_s       <= n_s;
        r_num.rem <= {r_d, pgcs_pkg::t_chan'(0)} - {pgcs_pkg::t_chan'(0), r_d};
        r_num.div <= r_s;
        r_num.quo <= '0;
    end

    assign w_st[0] = r_num;

    // Quotient never exceeds 255 since the numerator stays below 256 * span.
    for (genvar k = 0; k < pgcs_pkg::QUO_BITS; k++) begin : g_step
        pgcs_div_step #(
            .BIT(pgcs_pkg::QUO_BITS - 1 - k)
        ) u_step (
            .i_clk  (i_clk),
            .i_stage(w_st[k]),
            .o_stage(w_st[k+1])
        );
    end

    assign o_q = w_st[pgcs_pkg::QUO_BITS].quo;

endmodule

// ===== hw/rtl/pgcs_gray.sv =====
// Grayscale path: weighted sum, divide by 100, delay to match the stretch lanes.
`timescale 1ns / 1ps

module pgcs_gray (
    input  logic            i_clk,
    input  pgcs_pkg::t_chan i_red,
    input  pgcs_pkg::t_chan i_green,
    input  pgcs_pkg::t_chan i_blue,
    output pgcs_pkg::t_chan o_y
);

    localparam int unsigned DLY = pgcs_pkg::LANE_LAT - pgcs_pkg::GRAY_LAT;

    logic [pgcs_pkg::GRAY_SUM_W-1:0]  r_pb;
    logic [pgcs_pkg::GRAY_SUM_W-1:0]  r_pg;
    logic [pgcs_pkg::GRAY_SUM_W-1:0]  r_pr;
    logic [pgcs_pkg::GRAY_SUM_W-1:0]  r_sum;
    logic [pgcs_pkg::GRAY_PROD_W-1:0] w_prod;
    pgcs_pkg::t_chan                  r_y;
    pgcs_pkg::t_chan                  r_dly [0:DLY-1];

    // Multiply by the reciprocal of 100; exact for every reachable sum.
    assign w_prod = pgcs_pkg::GRAY_PROD_W'(r_sum)
                  * pgcs_pkg::GRAY_PROD_W'(pgcs_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        r_pb  <= pgcs_pkg::GRAY_SUM_W'(pgcs_pkg::W_LOW)  * pgcs_pkg::GRAY_SUM_W'(i_blue);
        r_pg  <= pgcs_pkg::GRAY_SUM_W'(pgcs_pkg::W_MID)  * pgcs_pkg::GRAY_SUM_W'(i_green);
        r_pr  <= pgcs_pkg::GRAY_SUM_W'(pgcs_pkg::W_HIGH) * pgcs_pkg::GRAY_SUM_W'(i_red);
        r_sum <= r_pb + r_pg + r_pr;
        r_y   <= w_prod[pgcs_pkg::RECIP_SHIFT +: pgcs_pkg::CHAN_W];
        r_dly[0] <= r_y;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    assign o_y = r_dly[DLY-1];

endmodule

// ===== hw/rtl/pixel_gray_and_contrast_stretch_core.sv =====
// Top level of the per-pixel grayscale / linear contrast stretch core.
`timescale 1ns / 1ps
//
//  Channel   | Direction | Handshake            | Beat contents
//  ----------+-----------+----------------------+-------------------------------------
//  config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//  pixel in  | in        | start & !busy        | i_alpha_in, i_red_in, i_green_in,
//            |           |                      | i_blue_in, i_last_in
//  pixel out | out       | o_valid (one cycle)  | o_alpha_out, o_red_out, o_green_out,
//            |           |                      | o_blue_out, o_last_out
//
//  One pixel beat may enter on every clock; busy is never raised.
//  Each beat passes through one clip stage, one numerator stage, eight
//  restoring divide stages (one quotient bit each) and the output register.
//  The divider chain sets the depth of the pipeline.
//  Reset (i_rst_n low at a clock edge) drops every beat in flight and loads
//  mode = grayscale, low level = 0, high level = 255.
//  The receiver cannot stall; results are never held back.
//  Write configuration only with no beat in flight (once the last started beat has come out).

`include "pixel_gray_and_contrast_stretch_core_macros.svh"

module pixel_gray_and_contrast_stretch_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [pgcs_pkg::CHAN_W-1:0] i_cfg_data,
    // pixel input
    input  logic                        start,
    output logic                        busy,
    input  logic [7:0]                  i_alpha_in,
    input  logic [7:0]                  i_red_in,
    input  logic [7:0]                  i_green_in,
    input  logic [7:0]                  i_blue_in,
    input  logic                        i_last_in,
    // pixel output
    output logic                        o_valid,
    output logic [7:0]                  o_alpha_out,
    output logic [7:0]                  o_red_out,
    output logic [7:0]                  o_green_out,
    output logic [7:0]                  o_blue_out,
    output logic                        o_last_out
);

    localparam int unsigned LAT = pgcs_pkg::LANE_LAT;

    // configuration registers
    logic            r_mode;
    pgcs_pkg::t_chan r_low;
    pgcs_pkg::t_chan r_high;

    // side band delay line that travels with the lanes
    logic            w_acc;
    logic            r_vld   [0:LAT-1];
    logic            r_last  [0:LAT-1];
    logic            r_md    [0:LAT-1];
    pgcs_pkg::t_chan r_alpha [0:LAT-1];

    // lane results, aligned with the last delay stage
    pgcs_pkg::t_chan w_red_q;
    pgcs_pkg::t_chan w_green_q;
    pgcs_pkg::t_chan w_blue_q;
    pgcs_pkg::t_chan w_gray_y;

    // output register
    logic            r_o_valid;
    logic            r_o_last;
    logic            r_o_mode;
    pgcs_pkg::t_chan r_o_alpha;
    pgcs_pkg::t_chan r_o_red;
    pgcs_pkg::t_chan r_o_green;
    pgcs_pkg::t_chan r_o_blue;

    // output beat qualifiers used by the checks below
    logic            w_gray_beat;
    logic            w_gray_same;

    // Every stage advances every cycle, so a new beat is always welcome.
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    // Config write: keep only the register's width, ignore unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pgcs_pkg::MODE_GRAY;
            r_low  <= '0;
            r_high <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pgcs_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                pgcs_pkg::CFG_LOW:  r_low  <= i_cfg_data;
                pgcs_pkg::CFG_HIGH: r_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the valid bits; reset drops everything in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
        end else begin
            r_vld[0] <= w_acc;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_o_valid <= r_vld[LAT-1];
            r_o_last  <= r_vld[LAT-1] & r_last[LAT-1];
        end
    end

    // Carry alpha, the last mark and the mode alongside the color lanes.
    always_ff @(posedge i_clk) begin
        r_alpha[0] <= i_alpha_in;
        r_last[0]  <= i_last_in;
        r_md[0]    <= r_mode;
        for (int i = 1; i < LAT; i++) begin
            r_alpha[i] <= r_alpha[i-1];
            r_last[i]  <= r_last[i-1];
            r_md[i]    <= r_md[i-1];
        end
    end

    pgcs_lane u_lane_red (
        .i_clk (i_clk),
        .i_v   (i_red_in),
        .i_low (r_low),
        .i_high(r_high),
        .o_q   (w_red_q)
    );

    pgcs_lane u_lane_green (
        .i_clk (i_clk),
        .i_v   (i_green_in),
        .i_low (r_low),
        .i_high(r_high),
        .o_q   (w_green_q)
    );

    pgcs_lane u_lane_blue (
        .i_clk (i_clk),
        .i_v   (i_blue_in),
        .i_low (r_low),
        .i_high(r_high),
        .o_q   (w_blue_q)
    );

    pgcs_gray u_gray (
        .i_clk  (i_clk),
        .i_red  (i_red_in),
        .i_green(i_green_in),
        .i_blue (i_blue_in),
        .o_y    (w_gray_y)
    );

    // Pick gray or stretched channels with the mode captured at entry.
    always_ff @(posedge i_clk) begin
        r_o_alpha <= r_alpha[LAT-1];
        r_o_mode  <= r_md[LAT-1];
        if (r_md[LAT-1] == pgcs_pkg::MODE_STRETCH) begin
            r_o_red   <= w_red_q;
            r_o_green <= w_green_q;
            r_o_blue  <= w_blue_q;
        end else begin
            r_o_red   <= w_gray_y;
            r_o_green <= w_gray_y;
            r_o_blue  <= w_gray_y;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_alpha_out = r_o_alpha;
    assign o_red_out   = r_o_red;
    assign o_green_out = r_o_green;
    assign o_blue_out  = r_o_blue;
    assign o_last_out  = r_o_last;

    assign w_gray_beat = o_valid && (r_o_mode == pgcs_pkg::MODE_GRAY);
    assign w_gray_same = (o_red_out == o_green_out) && (o_green_out == o_blue_out);

    // Each accepted beat comes out after the fixed pipeline latency.
    `PGCS_ASSERT_LATER(a_latency, i_clk, i_rst_n, w_acc, pgcs_pkg::PIPE_LAT, o_valid, "beat lost")

    // Grayscale beats carry one value on all three color channels.
    `PGCS_ASSERT_NOW(a_gray_equal, i_clk, i_rst_n, w_gray_beat, w_gray_same, "gray differs")

    // The last mark only rides on a valid result.
    `PGCS_ASSERT_NOW(a_last_valid, i_clk, i_rst_n, o_last_out, o_valid, "last without beat")

endmodule
